/* hdl/sts_pkg.sv */
`timescale 1ns / 1ps

package sts_pkg;

  localparam int ARG_W      = 31;
  localparam int SUM_W      = 32;
  localparam int CNT_W      = 7;
  localparam int RECIP_BITS = 32;
  localparam int PROD_W     = ARG_W + RECIP_BITS;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TERM_LIMIT = 1'd1;

  localparam logic [ARG_W-1:0] TOLERANCE_RESET  = 31'd1;
  localparam logic [CNT_W-1:0] TERM_LIMIT_RESET = 7'd100;

  typedef logic [ARG_W-1:0] arg_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_X2,
    ST_ADD,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic sq;
    logic x2_ld;
    logic add_term;
    logic mul_mag_x2;
    logic mul_recip;
    logic mag_ld;
  } dp_ctrl_t;

  typedef struct packed {
    logic stop;
  } dp_stat_t;

  // floor(2^32 / ((2k)(2k+1))); terms underflow to zero long before k reaches 16
  function automatic logic [RECIP_BITS-1:0] recip_of(input cnt_t k);
    logic [RECIP_BITS-1:0] r;
    case (k)
      7'd1:    r = 32'd715827882;
      7'd2:    r = 32'd214748364;
      7'd3:    r = 32'd102261126;
      7'd4:    r = 32'd59652323;
      7'd5:    r = 32'd39045157;
      7'd6:    r = 32'd27531841;
      7'd7:    r = 32'd20452225;
      7'd8:    r = 32'd15790320;
      7'd9:    r = 32'd12558383;
      7'd10:   r = 32'd10226112;
      7'd11:   r = 32'd8488077;
      7'd12:   r = 32'd7158278;
      7'd13:   r = 32'd6118187;
      7'd14:   r = 32'd5289368;
      7'd15:   r = 32'd4618244;
      7'd16:   r = 32'd4067203;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* hdl/sts_if.sv */
`timescale 1ns / 1ps

interface sts_in_if;
  import sts_pkg::*;
  logic valid;
  logic ready;
  arg_t argument;

  modport source (output valid, output argument, input ready);
  modport sink (input valid, input argument, output ready);
endinterface

interface sts_out_if;
  import sts_pkg::*;
  logic valid;
  logic ready;
  sum_t sine_sum;
  cnt_t term_count;

  modport source (output valid, output sine_sum, output term_count, input ready);
  modport sink (input valid, input sine_sum, input term_count, output ready);
endinterface

/* hdl/sts_ctrl.sv */
`timescale 1ns / 1ps

module sts_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_free,
  output logic              out_load,
  input  sts_pkg::dp_stat_t stat,
  output sts_pkg::dp_ctrl_t ctrl
);
  import sts_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SQ;
      end
      ST_SQ:   state_nxt = ST_X2;
      ST_X2:   state_nxt = ST_ADD;
      ST_ADD: begin
        state_nxt = stat.stop ? ST_DONE : ST_MUL1;
      end
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_MUL3;
      ST_MUL3: state_nxt = ST_ADD;
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl     = '0;
    in_ready = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        ctrl.load = in_valid;
      end
      ST_SQ:   ctrl.sq = 1'b1;
      ST_X2:   ctrl.x2_ld = 1'b1;
      ST_ADD:  ctrl.add_term = 1'b1;
      ST_MUL1: ctrl.mul_mag_x2 = 1'b1;
      ST_MUL2: ctrl.mul_recip = 1'b1;
      ST_MUL3: ctrl.mag_ld = 1'b1;
      ST_DONE: out_load = out_free;
      default: ctrl = '0;
    endcase
  end

endmodule

/* hdl/sts_dp.sv */
`timescale 1ns / 1ps

module sts_dp #(
  parameter int FRAC_BITS = 30
) (
  input  logic              clk,
  input  sts_pkg::dp_ctrl_t ctrl,
  input  sts_pkg::arg_t     argument,
  input  sts_pkg::arg_t     tolerance,
  input  sts_pkg::cnt_t     limit,
  output sts_pkg::dp_stat_t stat,
  output sts_pkg::sum_t     sum,
  output sts_pkg::cnt_t     count
);
  import sts_pkg::*;

  localparam int XW = (FRAC_BITS + 1 > ARG_W) ? FRAC_BITS + 1 : ARG_W;
  localparam logic [XW-1:0] ONE = {{(XW-1){1'b0}}, 1'b1} << FRAC_BITS;

  arg_t x_r, x2_r, mag_r;
  logic [PROD_W-1:0] prod_r;
  sum_t sum_r;
  cnt_t count_r;
  logic neg_r;

  logic [XW-1:0] arg_ext;
  arg_t x_sat;
  arg_t mul_a;
  logic [RECIP_BITS-1:0] mul_b;
  logic [PROD_W-1:0] prod_nxt;
  logic [PROD_W-1:0] prod_shift;
  cnt_t count_inc;
  sum_t mag_ext;

  assign arg_ext = XW'(argument);
  assign x_sat   = (arg_ext > ONE) ? ONE[ARG_W-1:0] : argument;

  assign prod_shift = prod_r >> FRAC_BITS;

  // shared multiplier operand select
  always_comb begin
    mul_a = x_r;
    mul_b = RECIP_BITS'(x_r);
    if (ctrl.mul_mag_x2) begin
      mul_a = mag_r;
      mul_b = RECIP_BITS'(x2_r);
    end else if (ctrl.mul_recip) begin
      mul_a = prod_shift[ARG_W-1:0];
      mul_b = recip_of(count_r);
    end
  end

  assign prod_nxt  = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign count_inc = count_r + 7'd1;
  assign mag_ext   = sum_t'(mag_r);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      x_r     <= x_sat;
      mag_r   <= x_sat;
      sum_r   <= '0;
      count_r <= '0;
      neg_r   <= 1'b0;
    end
    if (ctrl.sq || ctrl.mul_mag_x2 || ctrl.mul_recip) begin
      prod_r <= prod_nxt;
    end
    if (ctrl.x2_ld) begin
      x2_r <= prod_shift[ARG_W-1:0];
    end
    if (ctrl.add_term) begin
      sum_r   <= neg_r ? (sum_r - mag_ext) : (sum_r + mag_ext);
      count_r <= count_inc;
      neg_r   <= ~neg_r;
    end
    if (ctrl.mag_ld) begin
      mag_r <= prod_r[RECIP_BITS +: ARG_W];
    end
  end

  assign stat.stop = (count_inc >= limit) || (mag_r <= tolerance);
  assign sum       = sum_r;
  assign count     = count_r;

endmodule

/* hdl/sine_taylor_series_top.sv */
`timescale 1ns / 1ps

// Fixed-point sine of an argument in [0,1] (unsigned Q1.30, larger values clamp to 1.0) by
// its Maclaurin series, summed until a term's magnitude falls to the tolerance register or
// term_limit terms have been added; the result is the signed Q1.30 sum and the term count.
// One 31x32 multiplier is shared under a small sequencer. A request first squares the argument
// and loads its square, then for each term adds it to the sum, runs two multiplies and loads
// the next term, with the multiplies skipped after the last term, then waits in a done state
// until the output register is free and hands the result to it. At 1.0 with the reset
// tolerance seven terms are added. The input is not ready while a request is in progress,
// but a finished result waits in the output register so the next request can start before
// it is taken. Configuration should be written only while idle; the block itself does not
// enforce this.
module sine_taylor_series_top #(
  parameter int FRAC_BITS = 30
) (
  input  logic                 clk,
  input  logic                 rst_n,
  sts_in_if.sink               in_chan,
  sts_out_if.source            out_chan,
  input  logic                 cfg_we,
  input  sts_pkg::cfg_idx_t    cfg_index,
  input  sts_pkg::cfg_data_t   cfg_wdata
);
  import sts_pkg::*;

  arg_t tolerance_r;
  cnt_t term_limit_r;
  cnt_t lim_eff;

  logic out_valid_r;
  sum_t sine_sum_r;
  cnt_t term_count_r;

  logic out_free, out_load;
  dp_ctrl_t ctrl;
  dp_stat_t stat;
  sum_t dp_sum;
  cnt_t dp_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tolerance_r  <= TOLERANCE_RESET;
      term_limit_r <= TERM_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TOLERANCE:  tolerance_r <= cfg_wdata[ARG_W-1:0];
        CFG_TERM_LIMIT: term_limit_r <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // a limit of zero still adds the first term
  assign lim_eff = (term_limit_r == '0) ? 7'd1 : term_limit_r;

  assign out_free = !out_valid_r || out_chan.ready;

  sts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .out_free (out_free),
    .out_load (out_load),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  sts_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .ctrl      (ctrl),
    .argument  (in_chan.argument),
    .tolerance (tolerance_r),
    .limit     (lim_eff),
    .stat      (stat),
    .sum       (dp_sum),
    .count     (dp_count)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sine_sum_r   <= dp_sum;
      term_count_r <= dp_count;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.sine_sum   = sine_sum_r;
  assign out_chan.term_count = term_count_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("input ready while a request is in progress");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.term_count != '0))
    else $error("result with no terms added");

  a_count_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (dp_count <= lim_eff))
    else $error("term count beyond the limit");

  a_load_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |=> ($stable(sine_sum_r) && $stable(term_count_r)))
    else $error("pending result overwritten");

endmodule
